// ===== rtl/aavd_pkg.sv =====
// Package for the averaging voltmeter: widths, constants, FSM codes, control structs.
package aavd_pkg;

  localparam int MAX_SAMPLES_DEF = 16;
  localparam int ADC_W           = 10;
  localparam int CFG_W           = 5;
  localparam int VOLT_W          = 6;
  localparam int SEG_W           = 7;
  localparam int SCALED_W        = 16;
  localparam int SCALE_MUL       = 33;
  localparam int SCALE_ROUND     = 511;
  localparam int SCALE_DIV       = 1023;
  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(8);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_DIV1   = 5'b00010,
    ST_MUL    = 5'b00100,
    ST_HOLD   = 5'b01000,
    ST_FINISH = 5'b10000
  } state_t;

  typedef struct packed {
    logic accept;
    logic div_step;
    logic mul;
    logic hold;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic need_div;
    logic out_free;
  } status_t;

  function automatic logic [SEG_W-1:0] seg_code(input logic [3:0] d);
    logic [SEG_W-1:0] s;
    unique case (d)
      4'd0:    s = 7'h3F;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5B;
      4'd3:    s = 7'h4F;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6D;
      4'd6:    s = 7'h7D;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h6F;
      default: s = '0;
    endcase
    return s;
  endfunction

  // Tens digit of a value below 40.
  function automatic logic [1:0] tens_of(input logic [VOLT_W-1:0] v);
    logic [1:0] t;
    if (v >= VOLT_W'(30)) begin
      t = 2'd3;
    end else if (v >= VOLT_W'(20)) begin
      t = 2'd2;
    end else if (v >= VOLT_W'(10)) begin
      t = 2'd1;
    end else begin
      t = 2'd0;
    end
    return t;
  endfunction

endpackage

// ===== rtl/aavd_ctrl.sv =====
// Controller state machine: sequences accept, the mean division, scaling and output load.
module aavd_ctrl
  import aavd_pkg::*;
#(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  input  status_t stat,
  output cmd_t    cmd
);

  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W = ADC_W + CNT_W;
  localparam int DIV_W = (SUM_W > SCALED_W) ? SUM_W : SCALED_W;
  localparam int STP_W = $clog2(DIV_W);

  state_t           state_r, state_nxt;
  logic [STP_W-1:0] step_r, step_nxt;
  logic             accept;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid & in_tready;

  always_comb begin
    state_nxt    = state_r;
    step_nxt     = step_r;
    cmd          = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd.accept = 1'b1;
          step_nxt   = STP_W'(DIV_W - 1);
          state_nxt  = stat.need_div ? ST_DIV1 : ST_FINISH;
        end
      end
      ST_DIV1: begin
        cmd.div_step = 1'b1;
        if (step_r == '0) begin
          state_nxt = ST_MUL;
        end else begin
          step_nxt = step_r - 1'b1;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_HOLD;
      end
      ST_HOLD: begin
        cmd.hold  = 1'b1;
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

// ===== rtl/aavd_datapath.sv =====
// Datapath: sample accumulator, restoring divider for the mean, scaling, display and output.
module aavd_datapath
  import aavd_pkg::*;
#(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cmd_t             cmd,
  output status_t          stat,
  input  logic             func,
  input  logic [ADC_W-1:0] sample,
  input  logic [CFG_W-1:0] cfg_batch,
  input  logic             out_tready,
  output logic             out_tvalid,
  output logic [15:0]      out_tdata
);

  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W = ADC_W + CNT_W;
  localparam int DIV_W = (SUM_W > SCALED_W) ? SUM_W : SCALED_W;
  localparam int DVS_W = (CNT_W > ADC_W) ? CNT_W : ADC_W;
  localparam int BS_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  logic [SUM_W-1:0]  sum_r;
  logic [CNT_W-1:0]  taken_r;
  logic [VOLT_W-1:0] held_r;
  logic              show_high_r;
  logic [SEG_W-1:0]  seg_r;
  logic              high_sel_r;
  logic              upd_r;
  logic              out_valid_r;
  logic [15:0]       out_data_r;
  logic [DIV_W-1:0]  quo_r;
  logic [DVS_W-1:0]  rem_r;
  logic [DVS_W-1:0]  dvs_r;

  logic [SUM_W-1:0]    sum_inc;
  logic [CNT_W-1:0]    taken_inc;
  logic [BS_W-1:0]     cfg_ext, max_ext, bsize;
  logic                batch_done;
  logic [DVS_W:0]      trial;
  logic                ge;
  logic [SCALED_W-1:0] scaled;
  logic [VOLT_W-1:0]   q_est;
  logic [ADC_W:0]      r_est;
  logic [VOLT_W-1:0]   volts;
  logic [1:0]          tens;
  logic [VOLT_W-1:0]   ones;

  assign sum_inc   = sum_r + SUM_W'(sample);
  assign taken_inc = taken_r + 1'b1;
  assign cfg_ext   = BS_W'(cfg_batch);
  assign max_ext   = BS_W'(MAX_SAMPLES);

  always_comb begin
    if (cfg_ext == '0) begin
      bsize = BS_W'(1);
    end else if (cfg_ext > max_ext) begin
      bsize = max_ext;
    end else begin
      bsize = cfg_ext;
    end
  end

  assign batch_done    = (BS_W'(taken_inc) >= bsize);
  assign stat.need_div = ~func & batch_done;
  assign stat.out_free = ~out_valid_r | out_tready;

  assign trial  = {rem_r, quo_r[DIV_W-1]};
  assign ge     = (trial >= {1'b0, dvs_r});
  assign scaled = SCALED_W'(32'(quo_r[ADC_W-1:0]) * SCALE_MUL + SCALE_ROUND);

  // Divide by 2^ADC_W-1: estimate with a shift, then correct by one.
  assign q_est  = quo_r[ADC_W +: VOLT_W];
  assign r_est  = {1'b0, quo_r[ADC_W-1:0]} + (ADC_W+1)'(q_est);
  assign volts  = q_est + VOLT_W'(r_est >= (ADC_W+1)'(SCALE_DIV));

  assign tens   = tens_of(held_r);
  assign ones   = held_r - VOLT_W'(32'(tens) * 10);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      taken_r     <= '0;
      held_r      <= '0;
      show_high_r <= 1'b0;
      seg_r       <= '0;
      high_sel_r  <= 1'b1;
      upd_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.accept) begin
        upd_r <= 1'b0;
        if (func) begin
          high_sel_r  <= show_high_r;
          seg_r       <= show_high_r ? seg_code({2'b00, tens}) : seg_code(ones[3:0]);
          show_high_r <= ~show_high_r;
        end else if (batch_done) begin
          sum_r   <= '0;
          taken_r <= '0;
        end else begin
          sum_r   <= sum_inc;
          taken_r <= taken_inc;
        end
      end
      if (cmd.hold) begin
        held_r <= volts;
        upd_r  <= 1'b1;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      quo_r <= DIV_W'(sum_inc);
      rem_r <= '0;
      dvs_r <= DVS_W'(taken_inc);
    end else if (cmd.div_step) begin
      quo_r <= {quo_r[DIV_W-2:0], ge};
      rem_r <= ge ? DVS_W'(trial - {1'b0, dvs_r}) : DVS_W'(trial);
    end else if (cmd.mul) begin
      quo_r <= DIV_W'(scaled);
    end
    if (cmd.load_out) begin
      out_data_r <= {upd_r, held_r, ~high_sel_r, high_sel_r, seg_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== rtl/adc_average_voltmeter_display.sv =====
// Top level of the averaging voltmeter with two-digit seven-segment drive.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-----------------------------------------
//  in_     | in  | in_tvalid/tready   | tdata: sample_value; tuser: func
//  out_    | out | out_tvalid/tready  | tdata: segments, high/low on, volts, upd
//  cfg_    | in  | APB, pready high   | 0x0: samples_per_average (5 bits)
//
// A refresh tick or a sample that does not close a batch goes from accept straight
// to the output load. A sample that closes a batch runs the restoring divider for the
// mean, one quotient bit per cycle over DIV_W bits; the scaling by 33/1023 is a
// multiply step and then a shift-and-correct step before the output load.
// Reset is synchronous, active low; no clearing pass.
// A stalled output holds the result while the next word is taken in; the
// following result waits in the controller until the output register frees.
module adc_average_voltmeter_display
  import aavd_pkg::*;
#(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,    // [9:0] sample_value, [15:10] zero
  input  logic        in_tuser,    // [0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [6:0] segments, [7] high_digit_on, [8] low_digit_on,
                                   // [14:9] voltage_tenths, [15] voltage_updated
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam logic [2:0] ADDR_BATCH = 3'd0;

  logic [CFG_W-1:0] batch_r;
  cmd_t             cmd;
  status_t          stat;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == ADDR_BATCH) ? 32'(batch_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      batch_r <= CFG_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 (cfg_paddr == ADDR_BATCH)) begin
      batch_r <= cfg_pwdata[CFG_W-1:0];
    end
  end

  aavd_ctrl #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  aavd_datapath #(
    .MAX_SAMPLES(MAX_SAMPLES)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .func       (in_tuser),
    .sample     (in_tdata[ADC_W-1:0]),
    .cfg_batch  (batch_r),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the averaging voltmeter with seven-segment drive.
`timescale 1ns / 1ps

module testbench;
  import aavd_pkg::*;

  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_TICK   = 1'b1;
  localparam logic [2:0] ADDR_SAMPLES_PER_AVERAGE = 3'd0;
  localparam logic [2:0] ADDR_UNMAPPED            = 3'd4;
  localparam logic [SEG_W-1:0] DIGIT_PATTERN [10] = '{
    7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
  };
  localparam int RANDOM_WORDS = 450;
  localparam int SETTLE_CYCLES = 48;

  typedef struct packed {
    logic             func;
    logic [ADC_W-1:0] sample;
  } adc_word_t;

  typedef struct packed {
    logic              updated;
    logic [VOLT_W-1:0] volts;
    logic              low_on;
    logic              high_on;
    logic [SEG_W-1:0]  segments;
  } reading_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  adc_average_voltmeter_display dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [9:0] sample_value, [15:10] zero
    .in_tuser   (in_tuser),    // [0] func
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [6:0] segments, [7] high_digit_on, [8] low_digit_on,
                               // [14:9] voltage_tenths, [15] voltage_updated
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  adc_word_t pending_words[$];
  reading_t  expected_readings[$];
  adc_word_t in_word;

  logic [CFG_W-1:0]  batch_setting = CFG_RESET;
  int unsigned       acc_sum = 0;
  int unsigned       acc_count = 0;
  logic [VOLT_W-1:0] held_tenths = '0;
  logic              show_tens_next = 1'b0;
  logic [SEG_W-1:0]  drive_pattern = '0;
  logic              drive_tens = 1'b1;

  int words_queued = 0;
  int words_accepted = 0;
  int ticks_accepted = 0;
  int readings_checked = 0;
  int batches_closed = 0;
  int register_writes = 0;
  int mismatch_count = 0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_left = 0;
  int stall_mode = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic [SEG_W-1:0] digit_pattern(input int unsigned d);
    return (d < 10) ? DIGIT_PATTERN[d] : '0;
  endfunction

  task automatic voltmeter_predict(input adc_word_t w);
    reading_t    r;
    int unsigned batch;
    int unsigned mean;
    r.updated = 1'b0;
    if (w.func == FUNC_SAMPLE) begin
      acc_sum += w.sample;
      acc_count++;
      batch = batch_setting;
      if (batch < 1) batch = 1;
      if (batch > MAX_SAMPLES_DEF) batch = MAX_SAMPLES_DEF;
      if (acc_count >= batch) begin
        mean = acc_sum / acc_count;
        held_tenths = VOLT_W'((mean * SCALE_MUL + SCALE_ROUND) / SCALE_DIV);
        acc_sum = 0;
        acc_count = 0;
        r.updated = 1'b1;
      end
    end else begin
      if (show_tens_next) begin
        drive_tens = 1'b1;
        drive_pattern = digit_pattern(held_tenths / 10);
      end else begin
        drive_tens = 1'b0;
        drive_pattern = digit_pattern(held_tenths % 10);
      end
      show_tens_next = ~show_tens_next;
    end
    r.segments = drive_pattern;
    r.high_on  = drive_tens;
    r.low_on   = ~drive_tens;
    r.volts    = held_tenths;
    expected_readings.push_back(r);
  endtask

  task automatic check_reading(input reading_t got);
    reading_t want;
    if (expected_readings.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t: unexpected reading %h", $realtime, got);
      return;
    end
    want = expected_readings.pop_front();
    readings_checked++;
    if (got.updated) batches_closed++;
    if (got.segments !== want.segments || got.high_on !== want.high_on ||
        got.low_on !== want.low_on || got.volts !== want.volts ||
        got.updated !== want.updated) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t: reading %0d seg %h/%h hi %b/%b lo %b/%b volts %0d/%0d upd %b/%b (exp/act)",
                 $realtime, readings_checked, want.segments, got.segments,
                 want.high_on, got.high_on, want.low_on, got.low_on,
                 want.volts, got.volts, want.updated, got.updated);
    end
  endtask

  // Sender: bursts of words separated by random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        voltmeter_predict(in_word);
        words_accepted++;
        if (in_word.func == FUNC_TICK) ticks_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          in_word = pending_words.pop_front();
          in_tuser <= in_word.func;
          in_tdata <= {6'b0, in_word.sample};
          in_tvalid <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 16);
            case ($urandom_range(0, 3))
              0: gap_left = 0;
              1: gap_left = $urandom_range(1, 2);
              2: gap_left = $urandom_range(3, 8);
              default: gap_left = $urandom_range(0, 20);
            endcase
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check accepted words, stall in changing modes.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) check_reading(reading_t'(out_tdata));
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_left = $urandom_range(16, 96);
      end else begin
        stall_left--;
      end
      case (stall_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= 1'($urandom_range(0, 1));
        default: out_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  task automatic queue_word(input logic func, input logic [ADC_W-1:0] sample);
    adc_word_t w;
    w.func = func;
    w.sample = sample;
    pending_words.push_back(w);
    words_queued++;
  endtask

  task automatic write_register(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (addr == ADDR_SAMPLES_PER_AVERAGE) batch_setting = data[CFG_W-1:0];
    register_writes++;
  endtask

  // Wait until the sender is empty and every reading is back, then let the block settle.
  task automatic drain;
    @(negedge clk);
    while (pending_words.size() != 0 || in_tvalid || expected_readings.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [ADC_W-1:0] random_sample();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return ADC_W'($urandom_range(0, 31));
      3: return ADC_W'($urandom_range(992, 1023));
      default: return ADC_W'($urandom_range(0, 1023));
    endcase
  endfunction

  initial begin
    int unsigned setting;
    int          n;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    queue_word(FUNC_TICK, 10'h155);
    queue_word(FUNC_TICK, 10'h2AA);
    queue_word(FUNC_SAMPLE, 10'd0);
    queue_word(FUNC_SAMPLE, 10'd1023);
    queue_word(FUNC_SAMPLE, 10'd512);
    queue_word(FUNC_SAMPLE, 10'd1);
    queue_word(FUNC_SAMPLE, 10'h2AA);
    queue_word(FUNC_SAMPLE, 10'h155);
    queue_word(FUNC_SAMPLE, 10'd1023);
    queue_word(FUNC_SAMPLE, 10'd1023);
    queue_word(FUNC_TICK, 10'd0);
    queue_word(FUNC_TICK, 10'd1023);
    drain();

    write_register(ADDR_SAMPLES_PER_AVERAGE, 32'd1);
    queue_word(FUNC_SAMPLE, 10'd1023);
    queue_word(FUNC_TICK, 10'd0);
    queue_word(FUNC_TICK, 10'd0);
    queue_word(FUNC_SAMPLE, 10'd15);
    queue_word(FUNC_TICK, 10'd0);
    queue_word(FUNC_SAMPLE, 10'd16);
    queue_word(FUNC_TICK, 10'd0);
    drain();

    // Zero acts as one; an unmapped write changes nothing.
    write_register(ADDR_SAMPLES_PER_AVERAGE, 32'd0);
    write_register(ADDR_UNMAPPED, 32'hFFFF_FFFF);
    queue_word(FUNC_SAMPLE, 10'd700);
    queue_word(FUNC_TICK, 10'd0);
    queue_word(FUNC_TICK, 10'd0);
    drain();

    // Lower the batch size with a batch in progress.
    write_register(ADDR_SAMPLES_PER_AVERAGE, 32'hFFFF_FFF0);
    repeat (10) queue_word(FUNC_SAMPLE, random_sample());
    drain();
    write_register(ADDR_SAMPLES_PER_AVERAGE, 32'd3);
    queue_word(FUNC_SAMPLE, random_sample());
    queue_word(FUNC_TICK, 10'd0);
    drain();

    while (words_queued < RANDOM_WORDS - 25) begin
      case ($urandom_range(0, 9))
        0: setting = 0;
        1: setting = 1;
        2: setting = MAX_SAMPLES_DEF;
        3: setting = 31;
        4: setting = $urandom_range(17, 30);
        default: setting = $urandom_range(1, 16);
      endcase
      if ($urandom_range(0, 4) == 0) write_register(ADDR_UNMAPPED, $urandom());
      write_register(ADDR_SAMPLES_PER_AVERAGE,
                     {(32-CFG_W)'($urandom() >> CFG_W), CFG_W'(setting)});
      n = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 4) : $urandom_range(15, 45);
      repeat (n) begin
        if ($urandom_range(0, 9) < 3) queue_word(FUNC_TICK, ADC_W'($urandom()));
        else queue_word(FUNC_SAMPLE, random_sample());
      end
      drain();
    end

    $display("Covered %0d words (%0d refresh ticks), %0d readings checked, %0d batches closed,",
             words_accepted, ticks_accepted, readings_checked, batches_closed);
    $display("%0d register writes, %0d mismatches.", register_writes, mismatch_count);
    if (mismatch_count == 0 && expected_readings.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
